FILE: rtl/battery_cell_safety_monitor_core_defines.svh
// Assertion macros for the battery cell safety monitor.
// Used by rtl/battery_cell_safety_monitor_core.sv; no other dependencies.
`ifndef BATTERY_CELL_SAFETY_MONITOR_CORE_DEFINES_SVH
`define BATTERY_CELL_SAFETY_MONITOR_CORE_DEFINES_SVH

// Clocked property, checked outside reset.
`define BCSM_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define BCSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  `BCSM_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define BCSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `BCSM_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/bcsm_pkg.sv
// Types and constants for the battery cell safety monitor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bcsm_pkg;

  localparam int unsigned MvW = 16;

  // Register reset values in millivolts
  localparam logic [MvW-1:0] MinCellRst      = 16'd3300;
  localparam logic [MvW-1:0] UvExitRst       = 16'd3600;
  localparam logic [MvW-1:0] MaxCellRst      = 16'd4400;
  localparam logic [MvW-1:0] ImbLimitRst     = 16'd300;
  localparam logic [MvW-1:0] ImbExitRst      = 16'd100;

  typedef enum logic [2:0] {
    REG_MIN_CELL  = 3'd0,
    REG_UV_EXIT   = 3'd1,
    REG_MAX_CELL  = 3'd2,
    REG_IMB_LIMIT = 3'd3,
    REG_IMB_EXIT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CAUSE_SAFE    = 3'd0,
    CAUSE_UNDER   = 3'd1,
    CAUSE_OVER    = 3'd2,
    CAUSE_IMBAL   = 3'd3,
    CAUSE_HELD    = 3'd4,
    CAUSE_CLEARED = 3'd5
  } cause_e;

  typedef struct packed {
    logic [MvW-1:0] cell_one_mv;
    logic [MvW-1:0] cell_two_mv;
    logic [MvW-1:0] cell_three_mv;
  } in_t;

  typedef struct packed {
    logic   unsafe;
    cause_e cause;
    logic   undervolt_held;
    logic   imbalance_held;
  } out_t;

  typedef struct packed {
    logic [MvW-1:0] min_cell_mv;
    logic [MvW-1:0] undervolt_exit_mv;
    logic [MvW-1:0] max_cell_mv;
    logic [MvW-1:0] imbalance_limit_mv;
    logic [MvW-1:0] imbalance_exit_mv;
  } cfg_t;

  typedef struct packed {
    logic uv;
    logic imb;
  } latch_t;

endpackage

FILE: rtl/bcsm_cfg_regs.sv
// Threshold register file of the battery cell safety monitor.
// Depends on bcsm_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module bcsm_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [2:0]              wr_index_i,
  input  logic [bcsm_pkg::MvW-1:0] wr_data_i,
  output bcsm_pkg::cfg_t          cfg_o
);
  import bcsm_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes leave everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        REG_MIN_CELL:  cfg_d.min_cell_mv        = wr_data_i;
        REG_UV_EXIT:   cfg_d.undervolt_exit_mv  = wr_data_i;
        REG_MAX_CELL:  cfg_d.max_cell_mv        = wr_data_i;
        REG_IMB_LIMIT: cfg_d.imbalance_limit_mv = wr_data_i;
        REG_IMB_EXIT:  cfg_d.imbalance_exit_mv  = wr_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_cell_mv        <= MinCellRst;
      cfg_q.undervolt_exit_mv  <= UvExitRst;
      cfg_q.max_cell_mv        <= MaxCellRst;
      cfg_q.imbalance_limit_mv <= ImbLimitRst;
      cfg_q.imbalance_exit_mv  <= ImbExitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/bcsm_judge.sv
// Compare logic of the battery cell safety monitor: one reading in, one verdict out.
// Depends on bcsm_pkg for the payload, threshold and latch types.
`timescale 1ns / 1ps

module bcsm_judge (
  input  bcsm_pkg::in_t    beat_i,
  input  bcsm_pkg::cfg_t   cfg_i,
  input  bcsm_pkg::latch_t latch_i,
  output bcsm_pkg::out_t   res_o,
  output bcsm_pkg::latch_t latch_o
);
  import bcsm_pkg::*;

  logic [MvW-1:0] c1, c2, c3;
  logic [MvW-1:0] d12, d23, d31;
  logic           any_under, any_over, any_imb, all_uv_exit, all_imb_exit;
  latch_t         nxt;

  assign c1 = beat_i.cell_one_mv;
  assign c2 = beat_i.cell_two_mv;
  assign c3 = beat_i.cell_three_mv;

  // Absolute pairwise differences
  assign d12 = (c1 > c2) ? (c1 - c2) : (c2 - c1);
  assign d23 = (c2 > c3) ? (c2 - c3) : (c3 - c2);
  assign d31 = (c3 > c1) ? (c3 - c1) : (c1 - c3);

  // Threshold compares
  assign any_under = (c1 < cfg_i.min_cell_mv) || (c2 < cfg_i.min_cell_mv) ||
                     (c3 < cfg_i.min_cell_mv);
  assign any_over  = (c1 > cfg_i.max_cell_mv) || (c2 > cfg_i.max_cell_mv) ||
                     (c3 > cfg_i.max_cell_mv);
  assign any_imb   = (d12 > cfg_i.imbalance_limit_mv) || (d23 > cfg_i.imbalance_limit_mv) ||
                     (d31 > cfg_i.imbalance_limit_mv);
  assign all_uv_exit  = (c1 > cfg_i.undervolt_exit_mv) && (c2 > cfg_i.undervolt_exit_mv) &&
                        (c3 > cfg_i.undervolt_exit_mv);
  assign all_imb_exit = (d12 < cfg_i.imbalance_exit_mv) && (d23 < cfg_i.imbalance_exit_mv) &&
                        (d31 < cfg_i.imbalance_exit_mv);

  // Priority chain: undervolt, overvolt, imbalance, then latch release, then held latches
  always_comb begin
    nxt          = latch_i;
    res_o.unsafe = 1'b0;
    res_o.cause  = CAUSE_SAFE;
    if (any_under) begin
      nxt.uv       = 1'b1;
      res_o.unsafe = 1'b1;
      res_o.cause  = CAUSE_UNDER;
    end else if (any_over) begin
      res_o.unsafe = 1'b1;
      res_o.cause  = CAUSE_OVER;
    end else if (any_imb) begin
      nxt.imb      = 1'b1;
      res_o.unsafe = 1'b1;
      res_o.cause  = CAUSE_IMBAL;
    end else if (latch_i.uv && all_uv_exit) begin
      nxt.uv       = 1'b0;
      res_o.unsafe = latch_i.imb;
      res_o.cause  = CAUSE_CLEARED;
    end else if (latch_i.imb && all_imb_exit) begin
      nxt.imb      = 1'b0;
      res_o.unsafe = latch_i.uv;
      res_o.cause  = CAUSE_CLEARED;
    end else if (latch_i.uv || latch_i.imb) begin
      res_o.unsafe = 1'b1;
      res_o.cause  = CAUSE_HELD;
    end
    res_o.undervolt_held = nxt.uv;
    res_o.imbalance_held = nxt.imb;
  end

  assign latch_o = nxt;

endmodule

FILE: rtl/battery_cell_safety_monitor_core.sv
// Top level of the battery cell safety monitor: input stage, judge, result stage.
// Depends on bcsm_pkg, bcsm_cfg_regs, bcsm_judge and the assertion macro header.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | in        | in_valid_i / in_ready_o  | in_beat_i   (three cells)
//   out     | out       | out_valid_o / out_ready_i| out_beat_o  (verdict)
//   cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One reading per cycle unless the output stalls; both stages are registered.
// The sticky latches update as a reading moves from the input stage to the result
// stage, so the next reading already sees them.
// Reset clears the stages and latches and loads the default thresholds.
// A stalled result holds the result stage; the input stage still takes one beat.
`timescale 1ns / 1ps
`include "battery_cell_safety_monitor_core_defines.svh"

module battery_cell_safety_monitor_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  bcsm_pkg::in_t            in_beat_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bcsm_pkg::out_t           out_beat_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [bcsm_pkg::MvW-1:0] cfg_data_i
);
  import bcsm_pkg::*;

  cfg_t   cfg;
  in_t    s1_q;
  logic   s1_valid_q;
  out_t   out_q, res;
  logic   out_valid_q;
  latch_t latch_q, latch_nxt;
  logic   s1_fire, in_fire;

  // Threshold registers
  assign cfg_ready_o = 1'b1;

  bcsm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the input stage when the result stage is free or draining
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_beat_i;
    end
  end

  bcsm_judge u_judge (
    .beat_i  (s1_q),
    .cfg_i   (cfg),
    .latch_i (latch_q),
    .res_o   (res),
    .latch_o (latch_nxt)
  );

  // Commit latches with the reading that produced them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
    end else if (s1_fire) begin
      latch_q <= latch_nxt;
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // Checks
  `BCSM_ASSERT_IMPL(a_latch_matches_out, out_valid_q, (latch_q.uv == out_q.undervolt_held) && (latch_q.imb == out_q.imbalance_held), "latches disagree with last verdict")
  `BCSM_ASSERT_IMPL(a_under_sets_flag, out_valid_q && (out_q.cause == CAUSE_UNDER), out_q.undervolt_held && out_q.unsafe, "undervolt verdict without flag")
  `BCSM_ASSERT_IMPL(a_safe_clean, out_valid_q && (out_q.cause == CAUSE_SAFE), !out_q.unsafe && !out_q.undervolt_held && !out_q.imbalance_held, "safe verdict with flag held")
  `BCSM_ASSERT_IMPL(a_cleared_unsafe, out_valid_q && (out_q.cause == CAUSE_CLEARED), out_q.unsafe == (out_q.undervolt_held || out_q.imbalance_held), "cleared verdict disagrees with flags")
  `BCSM_ASSERT_NEXT(a_latch_hold, !s1_fire, $stable(latch_q), "latches moved without a reading")

endmodule
